// File: rtl/sui_pkg.sv
// shared types, codes and sizes for the two-set union / intersection / difference engine
`default_nettype none

package sui_pkg;

    // capacity of each set, and the widths that follow from it
    localparam int MAX_ELEMS = 16;
    localparam int CW        = $clog2(MAX_ELEMS + 1);
    localparam int IW        = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

    // request codes
    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_LOAD_A  = 2'd1;
    localparam logic [1:0] REQ_LOAD_B  = 2'd2;
    localparam logic [1:0] REQ_COMPUTE = 2'd3;

    // set operation codes
    localparam logic [1:0] OP_UNION = 2'd0;
    localparam logic [1:0] OP_INTER = 2'd1;
    localparam logic [1:0] OP_DIFF  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_ELEMENT   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] elem_value;
        logic [1:0]         set_op;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [2:0]         status;
        logic               last;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LD_SCAN,
        S_OFETCH,
        S_OKEY,
        S_CSCAN,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_CLEAR,
        EM_LOAD,
        EM_DECIDE,
        EM_FINISH
    } emit_t;

    // controller to datapath
    typedef struct packed {
        logic  capture;
        logic  scan_init;
        logic  scan_run;
        logic  inner_is_a;
        logic  outer_init;
        logic  rd_outer;
        logic  key_from_outer;
        emit_t emit;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] set_op;
        logic       scan_done;
        logic       outer_end;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/sui_dp.sv
// datapath: set stores, scan compare, pending result and output register
`default_nettype none

module sui_dp (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire sui_pkg::req_t cmd,
    input  wire sui_pkg::ctl_t ctl,
    output sui_pkg::stat_t    stat,
    output logic              valid,
    output sui_pkg::rsp_t     result
);

    logic [31:0] mem_a [sui_pkg::MAX_ELEMS];
    logic [31:0] mem_b [sui_pkg::MAX_ELEMS];

    sui_pkg::req_t              req_reg, req_next;
    logic [sui_pkg::CW-1:0]     cnt_a_reg, cnt_a_next;
    logic [sui_pkg::CW-1:0]     cnt_b_reg, cnt_b_next;
    logic [sui_pkg::CW-1:0]     outer_idx_reg, outer_idx_next;
    logic [sui_pkg::CW-1:0]     inner_idx_reg, inner_idx_next;
    logic                       rd_ok_reg, rd_ok_next;
    logic                       hit_reg, hit_next;
    logic                       pend_reg, pend_next;
    logic [31:0]                pend_val_reg, pend_val_next;
    logic [31:0]                key_reg, key_next;
    logic [31:0]                rd_a_reg, rd_b_reg;
    logic                       valid_reg, valid_next;
    sui_pkg::rsp_t              result_reg, result_next;

    logic [sui_pkg::CW-1:0]     inner_cnt, outer_cnt;
    logic [31:0]                rd_inner, rd_outer;
    logic [sui_pkg::IW-1:0]     addr_a, addr_b;
    logic                       scan_issue;
    logic                       match;
    logic                       take;
    logic                       full;
    logic                       load_ok;

    assign inner_cnt = ctl.inner_is_a ? cnt_a_reg : cnt_b_reg;
    assign outer_cnt = ctl.inner_is_a ? cnt_b_reg : cnt_a_reg;
    assign rd_inner  = ctl.inner_is_a ? rd_a_reg : rd_b_reg;
    assign rd_outer  = ctl.inner_is_a ? rd_b_reg : rd_a_reg;

    // one read address per store: outer fetch or scan position
    assign addr_a = (ctl.rd_outer && !ctl.inner_is_a) ? outer_idx_reg[sui_pkg::IW-1:0]
                                                       : inner_idx_reg[sui_pkg::IW-1:0];
    assign addr_b = (ctl.rd_outer && ctl.inner_is_a) ? outer_idx_reg[sui_pkg::IW-1:0]
                                                      : inner_idx_reg[sui_pkg::IW-1:0];

    assign scan_issue = ctl.scan_run && (inner_idx_reg < inner_cnt);
    assign match      = rd_ok_reg && (rd_inner == key_reg);
    assign full       = (inner_cnt == sui_pkg::CW'(sui_pkg::MAX_ELEMS));
    assign load_ok    = !hit_reg && !full;

    // first pass picks A values by set_op; union's second pass keeps B not in A
    always_comb
    begin
        if (ctl.inner_is_a)
        begin
            take = !hit_reg;
        end
        else
        begin
            unique case (req_reg.set_op)
                sui_pkg::OP_UNION: take = 1'b1;
                sui_pkg::OP_INTER: take = hit_reg;
                sui_pkg::OP_DIFF:  take = !hit_reg;
                default:           take = 1'b0;
            endcase
        end
    end

    assign stat.req_type  = req_reg.req_type;
    assign stat.set_op    = req_reg.set_op;
    assign stat.scan_done = (inner_idx_reg == inner_cnt) && !rd_ok_reg;
    assign stat.outer_end = (outer_idx_reg == outer_cnt);

    always_comb
    begin
        req_next       = req_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        outer_idx_next = outer_idx_reg;
        inner_idx_next = inner_idx_reg;
        rd_ok_next     = rd_ok_reg;
        hit_next       = hit_reg;
        pend_next      = pend_reg;
        pend_val_next  = pend_val_reg;
        key_next       = key_reg;
        valid_next     = 1'b0;
        result_next    = result_reg;

        if (ctl.capture)
        begin
            req_next  = cmd;
            key_next  = cmd.elem_value;
            pend_next = 1'b0;
        end

        if (ctl.key_from_outer)
        begin
            key_next = rd_outer;
        end

        if (ctl.outer_init)
        begin
            outer_idx_next = '0;
        end

        if (ctl.scan_init)
        begin
            inner_idx_next = '0;
            rd_ok_next     = 1'b0;
            hit_next       = 1'b0;
        end
        else if (ctl.scan_run)
        begin
            rd_ok_next = scan_issue;
            hit_next   = hit_reg | match;
            if (scan_issue)
            begin
                inner_idx_next = inner_idx_reg + sui_pkg::CW'(1);
            end
        end

        unique case (ctl.emit)
            sui_pkg::EM_NONE:
            begin
            end
            sui_pkg::EM_CLEAR:
            begin
                cnt_a_next            = '0;
                cnt_b_next            = '0;
                valid_next            = 1'b1;
                result_next.out_value = '0;
                result_next.status    = sui_pkg::ST_ACCEPTED;
                result_next.last      = 1'b1;
            end
            sui_pkg::EM_LOAD:
            begin
                valid_next            = 1'b1;
                result_next.out_value = '0;
                result_next.last      = 1'b1;
                if (hit_reg)
                begin
                    result_next.status = sui_pkg::ST_DUPLICATE;
                end
                else if (full)
                begin
                    result_next.status = sui_pkg::ST_FULL;
                end
                else
                begin
                    result_next.status = sui_pkg::ST_ACCEPTED;
                    if (ctl.inner_is_a)
                    begin
                        cnt_a_next = cnt_a_reg + sui_pkg::CW'(1);
                    end
                    else
                    begin
                        cnt_b_next = cnt_b_reg + sui_pkg::CW'(1);
                    end
                end
            end
            sui_pkg::EM_DECIDE:
            begin
                outer_idx_next = outer_idx_reg + sui_pkg::CW'(1);
                if (take)
                begin
                    // held word goes out now that a later one exists
                    if (pend_reg)
                    begin
                        valid_next            = 1'b1;
                        result_next.out_value = pend_val_reg;
                        result_next.status    = sui_pkg::ST_ELEMENT;
                        result_next.last      = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_val_next = key_reg;
                end
            end
            sui_pkg::EM_FINISH:
            begin
                valid_next       = 1'b1;
                result_next.last = 1'b1;
                pend_next        = 1'b0;
                if (pend_reg)
                begin
                    result_next.out_value = pend_val_reg;
                    result_next.status    = sui_pkg::ST_ELEMENT;
                end
                else
                begin
                    result_next.out_value = '0;
                    result_next.status    = sui_pkg::ST_EMPTY;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            outer_idx_reg <= '0;
            inner_idx_reg <= '0;
            rd_ok_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            outer_idx_reg <= outer_idx_next;
            inner_idx_reg <= inner_idx_next;
            rd_ok_reg     <= rd_ok_next;
            hit_reg       <= hit_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        key_reg      <= key_next;
        pend_val_reg <= pend_val_next;
        result_reg   <= result_next;
    end

    // set stores, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.emit == sui_pkg::EM_LOAD && load_ok && ctl.inner_is_a)
        begin
            mem_a[cnt_a_reg[sui_pkg::IW-1:0]] <= key_reg;
        end
        rd_a_reg <= mem_a[addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit == sui_pkg::EM_LOAD && load_ok && !ctl.inner_is_a)
        begin
            mem_b[cnt_b_reg[sui_pkg::IW-1:0]] <= key_reg;
        end
        rd_b_reg <= mem_b[addr_b];
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/sui_ctrl.sv
// controller state machine sequencing loads, clears and set operations
`default_nettype none

module sui_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire sui_pkg::stat_t stat,
    output sui_pkg::ctl_t       ctl,
    output logic                busy
);

    sui_pkg::state_t state_reg, state_next;
    logic            pass_reg, pass_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sui_pkg::S_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        pass_next          = pass_reg;
        ctl.capture        = 1'b0;
        ctl.scan_init      = 1'b0;
        ctl.scan_run       = 1'b0;
        ctl.inner_is_a     = pass_reg;
        ctl.outer_init     = 1'b0;
        ctl.rd_outer       = 1'b0;
        ctl.key_from_outer = 1'b0;
        ctl.emit           = sui_pkg::EM_NONE;

        unique case (state_reg)
            sui_pkg::S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = sui_pkg::S_DECODE;
                end
            end
            sui_pkg::S_DECODE:
            begin
                unique case (stat.req_type)
                    sui_pkg::REQ_CLEAR:
                    begin
                        ctl.emit   = sui_pkg::EM_CLEAR;
                        state_next = sui_pkg::S_IDLE;
                    end
                    sui_pkg::REQ_LOAD_A, sui_pkg::REQ_LOAD_B:
                    begin
                        ctl.scan_init = 1'b1;
                        state_next    = sui_pkg::S_LD_SCAN;
                    end
                    default:
                    begin
                        pass_next      = 1'b0;
                        ctl.outer_init = 1'b1;
                        if (stat.set_op == sui_pkg::OP_UNION
                            || stat.set_op == sui_pkg::OP_INTER
                            || stat.set_op == sui_pkg::OP_DIFF)
                        begin
                            state_next = sui_pkg::S_OFETCH;
                        end
                        else
                        begin
                            state_next = sui_pkg::S_FINISH;
                        end
                    end
                endcase
            end
            sui_pkg::S_LD_SCAN:
            begin
                ctl.inner_is_a = (stat.req_type == sui_pkg::REQ_LOAD_A);
                ctl.scan_run   = 1'b1;
                if (stat.scan_done)
                begin
                    ctl.emit   = sui_pkg::EM_LOAD;
                    state_next = sui_pkg::S_IDLE;
                end
            end
            sui_pkg::S_OFETCH:
            begin
                if (stat.outer_end)
                begin
                    if (!pass_reg && stat.set_op == sui_pkg::OP_UNION)
                    begin
                        pass_next      = 1'b1;
                        ctl.outer_init = 1'b1;
                    end
                    else
                    begin
                        state_next = sui_pkg::S_FINISH;
                    end
                end
                else
                begin
                    ctl.rd_outer = 1'b1;
                    state_next   = sui_pkg::S_OKEY;
                end
            end
            sui_pkg::S_OKEY:
            begin
                ctl.key_from_outer = 1'b1;
                ctl.scan_init      = 1'b1;
                state_next         = sui_pkg::S_CSCAN;
            end
            sui_pkg::S_CSCAN:
            begin
                ctl.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    ctl.emit   = sui_pkg::EM_DECIDE;
                    state_next = sui_pkg::S_OFETCH;
                end
            end
            sui_pkg::S_FINISH:
            begin
                ctl.emit   = sui_pkg::EM_FINISH;
                state_next = sui_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sui_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != sui_pkg::S_IDLE);

endmodule

`default_nettype wire

// File: rtl/set_union_intersect_difference.sv
// top level of the two-set union / intersection / difference engine
`default_nettype none

// Holds two sets, A and B, of up to MAX_ELEMS distinct 32-bit values each, in
// load order. A command word is taken when start is high and busy is low.
// Every command answers with one or more result words, each shown on result
// for exactly one cycle with valid high; there is no backpressure, so the
// receiver must take every word when it appears. The final word of a command
// has last set. Clear and load commands answer with a single status word.
// A compute command streams the union (A, then the B values not in A), the
// intersection (A values found in B) or the difference (A values not in B),
// or one empty-result word if nothing qualifies or the op code is unused. A load
// scans the held entries of its set, comparing the value against them one per
// cycle through the store's registered read port. A compute walks the outer set
// and, for each outer entry, scans the other set one compare per cycle; union
// runs two passes, A against B and then B against A. The next command can be
// taken in the cycle after the last word is registered.

module set_union_intersect_difference (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire sui_pkg::req_t cmd,
    output logic               busy,
    output logic               valid,
    output sui_pkg::rsp_t      result
);

    // command and status between sequencer and datapath
    sui_pkg::ctl_t  ctl;
    sui_pkg::stat_t stat;

    // sequencer: decodes the captured word and runs the scan loops
    sui_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // datapath: stores, compare, held result word and output register
    sui_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .stat   (stat),
        .valid  (valid),
        .result (result)
    );

endmodule

`default_nettype wire

// File: dv/set_union_intersect_difference_tb.sv
// testbench for the two-set union / intersection / difference engine
`timescale 1ns / 100ps

module set_union_intersect_difference_tb;

    import sui_pkg::*;

    // set selectors for the local copy of the two stores
    localparam int SIDE_A = 0;
    localparam int SIDE_B = 1;

    // the op code the block has no operation for: it answers with an empty marker
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 360;
    localparam int TAIL_CYCLES = 64;

    // slowest silent span: an intersection over two full sets with no match walks
    // 16 outer entries, each scanning 16 inner entries plus fetch and key overhead;
    // sender gaps add little. limit is that span taken about ten times over
    localparam int WATCHDOG_LIMIT = 4000;

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    req_t  cmd   = '0;
    logic  busy;
    logic  valid;
    rsp_t  result;

    // words still owed by the block, oldest first
    rsp_t  reply_words [$];

    // local copy of the two sets, in load order
    logic [31:0] held_vals [2][MAX_ELEMS];
    int          held_cnt  [2];

    // sender idle chance, in percent per cycle
    int idle_pct = 7;

    int items_sent;
    int words_checked;
    int mismatches;
    int dup_drops;
    int full_drops;
    int longest_reply;
    int ops_seen [4];
    int quiet_cycles;

    set_union_intersect_difference u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .valid  (valid),
        .result (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    task automatic queue_reply_word(input logic [31:0] v, input logic [2:0] st,
                                    input logic lst);
        rsp_t w;
        w.out_value = v;
        w.status    = st;
        w.last      = lst;
        reply_words.push_back(w);
    endtask

    // linear search over the filled part of one set only, so unwritten
    // entries never take part
    function automatic bit set_holds(input int side, input logic [31:0] v);
        int i;
        for (i = 0; i < held_cnt[side]; i++)
            if (held_vals[side][i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    // duplicate check comes first, so a repeat into a full set reads as duplicate
    function automatic logic [2:0] load_status(input int side, input logic [31:0] v);
        if (set_holds(side, v))
        begin
            dup_drops++;
            return ST_DUPLICATE;
        end
        if (held_cnt[side] >= MAX_ELEMS)
        begin
            full_drops++;
            return ST_FULL;
        end
        held_vals[side][held_cnt[side]] = v;
        held_cnt[side]++;
        return ST_ACCEPTED;
    endfunction

    // works out every word one accepted command causes and queues them
    task automatic predict_reply(input req_t w);
        logic [31:0] picks [$];
        logic        in_b;
        int          i;
        case (w.req_type)
            REQ_CLEAR:
            begin
                held_cnt[SIDE_A] = 0;
                held_cnt[SIDE_B] = 0;
                queue_reply_word('0, ST_ACCEPTED, 1'b1);
            end
            REQ_LOAD_A:
                queue_reply_word('0, load_status(SIDE_A, w.elem_value), 1'b1);
            REQ_LOAD_B:
                queue_reply_word('0, load_status(SIDE_B, w.elem_value), 1'b1);
            REQ_COMPUTE:
            begin
                ops_seen[w.set_op]++;
                if (w.set_op != OP_UNUSED)
                begin
                    // A-first pass: union, intersection and difference all walk A in load order
                    for (i = 0; i < held_cnt[SIDE_A]; i++)
                    begin
                        in_b = set_holds(SIDE_B, held_vals[SIDE_A][i]);
                        if (w.set_op == OP_UNION || (w.set_op == OP_INTER && in_b) ||
                            (w.set_op == OP_DIFF && !in_b))
                            picks.push_back(held_vals[SIDE_A][i]);
                    end
                    // union adds the B values missing from A
                    if (w.set_op == OP_UNION)
                        for (i = 0; i < held_cnt[SIDE_B]; i++)
                            if (!set_holds(SIDE_A, held_vals[SIDE_B][i]))
                                picks.push_back(held_vals[SIDE_B][i]);
                end
                if (picks.size() == 0)
                    queue_reply_word('0, ST_EMPTY, 1'b1);
                else
                    for (i = 0; i < picks.size(); i++)
                        queue_reply_word(picks[i], ST_ELEMENT, i == picks.size() - 1);
                if (picks.size() > longest_reply)
                    longest_reply = picks.size();
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_word(input rsp_t got);
        rsp_t want;
        if (reply_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word: value %0d status %0d last %0b",
                                      got.out_value, got.status, got.last));
            return;
        end
        want = reply_words.pop_front();
        words_checked++;
        if (got.out_value !== want.out_value)
            report_mismatch($sformatf("word %0d out_value %0d, want %0d",
                                      words_checked, got.out_value, want.out_value));
        if (got.status !== want.status)
            report_mismatch($sformatf("word %0d status %0d, want %0d",
                                      words_checked, got.status, want.status));
        if (got.last !== want.last)
            report_mismatch($sformatf("word %0d last %0b, want %0b",
                                      words_checked, got.last, want.last));
    endtask

    // no backpressure: every strobed word is taken at the edge ending its cycle
    always @(posedge clk)
    begin
        if (rst_n && valid)
            check_word(result);
    end

    // counts edges where neither a command nor a result word is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: %0d cycles with nothing taken, %0d words owed",
                         quiet_cycles, reply_words.size());
                $display("set_union_intersect_difference_tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // drives one command word at falling edges, with random idle cycles, until
    // an edge sees start high and busy low; start drops at the next falling edge
    task automatic issue_cmd(input req_t w);
        bit taken;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            start <= ($urandom_range(0, 99) >= idle_pct);
            cmd   <= w;
            @(posedge clk);
            if (start && !busy)
                taken = 1'b1;
        end
        predict_reply(w);
        items_sent++;
        @(negedge clk);
        start <= 1'b0;
    endtask

    // unused fields carry random bits, since the block must ignore them
    function automatic req_t clear_cmd();
        req_t w;
        w.req_type   = REQ_CLEAR;
        w.elem_value = $urandom;
        w.set_op     = 2'($urandom_range(0, 3));
        return w;
    endfunction

    function automatic req_t load_cmd(input int side, input logic [31:0] v);
        req_t w;
        w.req_type   = (side == SIDE_A) ? REQ_LOAD_A : REQ_LOAD_B;
        w.elem_value = v;
        w.set_op     = 2'($urandom_range(0, 3));
        return w;
    endfunction

    function automatic req_t compute_cmd(input logic [1:0] op);
        req_t w;
        w.req_type   = REQ_COMPUTE;
        w.elem_value = $urandom;
        w.set_op     = op;
        return w;
    endfunction

    // anything the fields allow
    function automatic req_t noise_cmd();
        req_t w;
        w.req_type   = 2'($urandom_range(0, 3));
        w.elem_value = $urandom;
        w.set_op     = 2'($urandom_range(0, 3));
        return w;
    endfunction

    function automatic logic [1:0] pick_op();
        logic [1:0] op_list [3];
        op_list = '{OP_UNION, OP_INTER, OP_DIFF};
        if ($urandom_range(0, 9) == 0)
            return OP_UNUSED;
        return op_list[$urandom_range(0, 2)];
    endfunction

    // empty sets, value extremes, duplicates, all four op codes, subset giving
    // an empty difference, and a compute right after clear
    task automatic test_directed_edges();
        issue_cmd(clear_cmd());
        issue_cmd(compute_cmd(OP_UNION));
        issue_cmd(compute_cmd(OP_INTER));
        issue_cmd(compute_cmd(OP_DIFF));
        issue_cmd(compute_cmd(OP_UNUSED));
        issue_cmd(load_cmd(SIDE_A, 32'h8000_0000));
        issue_cmd(load_cmd(SIDE_A, 32'h7FFF_FFFF));
        issue_cmd(load_cmd(SIDE_A, 32'h0000_0000));
        issue_cmd(load_cmd(SIDE_A, 32'hFFFF_FFFF));
        issue_cmd(load_cmd(SIDE_A, 32'h7FFF_FFFF));
        issue_cmd(load_cmd(SIDE_B, 32'hFFFF_FFFF));
        issue_cmd(load_cmd(SIDE_B, 32'h0000_0005));
        issue_cmd(load_cmd(SIDE_B, 32'h8000_0000));
        issue_cmd(load_cmd(SIDE_B, 32'h0000_0005));
        issue_cmd(compute_cmd(OP_UNION));
        issue_cmd(compute_cmd(OP_INTER));
        issue_cmd(compute_cmd(OP_DIFF));
        issue_cmd(compute_cmd(OP_UNUSED));
        // B now covers all of A, so A minus B is empty
        issue_cmd(load_cmd(SIDE_B, 32'h0000_0000));
        issue_cmd(load_cmd(SIDE_B, 32'h7FFF_FFFF));
        issue_cmd(compute_cmd(OP_DIFF));
        issue_cmd(clear_cmd());
        issue_cmd(compute_cmd(OP_UNION));
    endtask

    // both sets filled with disjoint values: drops on full, duplicate into a
    // full set, and the longest union of 2 * MAX_ELEMS words
    task automatic test_full_capacity();
        logic [31:0] base_a;
        logic [31:0] base_b;
        int          k;
        base_a = $urandom;
        base_b = base_a + 32'h1000_0000;
        issue_cmd(clear_cmd());
        for (k = 0; k < MAX_ELEMS; k++)
        begin
            issue_cmd(load_cmd(SIDE_A, base_a + k));
            issue_cmd(load_cmd(SIDE_B, base_b + k));
        end
        issue_cmd(load_cmd(SIDE_A, base_b));
        issue_cmd(load_cmd(SIDE_A, base_a + 3));
        issue_cmd(load_cmd(SIDE_B, base_a));
        issue_cmd(load_cmd(SIDE_B, base_b + MAX_ELEMS - 1));
        issue_cmd(compute_cmd(OP_UNION));
        issue_cmd(compute_cmd(OP_INTER));
        issue_cmd(compute_cmd(OP_DIFF));
    endtask

    // one well-formed session: optional clear, loads drawn from a small pool so
    // duplicates and A/B overlap are common, then a few computes; a few noise words
    task automatic run_session(input int load_cap, input bit wipe);
        logic [31:0] pool [$];
        logic [31:0] v;
        int          n_pool;
        int          n_loads;
        int          n_comp;
        int          k;
        n_pool = $urandom_range(2, load_cap + 2);
        for (k = 0; k < n_pool; k++)
        begin
            // half full-range values, half small signed ones around zero
            if ($urandom_range(0, 1))
                v = $urandom;
            else
            begin
                v = $urandom_range(0, 40);
                v = v - 32'd20;
            end
            pool.push_back(v);
        end
        if (wipe)
            issue_cmd(clear_cmd());
        n_loads = $urandom_range(0, load_cap);
        for (k = 0; k < n_loads; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                issue_cmd(noise_cmd());
            else
                issue_cmd(load_cmd($urandom_range(0, 1),
                                   pool[$urandom_range(0, pool.size() - 1)]));
        end
        n_comp = $urandom_range(1, 4);
        for (k = 0; k < n_comp; k++)
            issue_cmd(compute_cmd(pick_op()));
    endtask

    // sender never idles here, so commands land the cycle busy drops
    task automatic test_no_idle_stretch();
        int k;
        idle_pct = 0;
        for (k = 0; k < 5; k++)
            run_session(8, 1'b1);
        idle_pct = 7;
    endtask

    // mostly small sets; now and then large pools or no clear, which fills sets
    task automatic test_random_sessions();
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                run_session(40, $urandom_range(0, 1));
            else
                run_session(10, $urandom_range(0, 4) != 0);
        end
    endtask

    task automatic finish_run();
        while (reply_words.size() != 0)
            @(posedge clk);
        // catch stray words after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("summary: %0d commands, %0d result words checked, longest reply %0d words",
                 items_sent, words_checked, longest_reply);
        $display("summary: computes union %0d inter %0d diff %0d unused-op %0d, %0d dup, %0d full",
                 ops_seen[OP_UNION], ops_seen[OP_INTER], ops_seen[OP_DIFF],
                 ops_seen[OP_UNUSED], dup_drops, full_drops);
        if (mismatches == 0)
            $display("set_union_intersect_difference_tb: clean");
        else
            $display("set_union_intersect_difference_tb: errors");
        $finish;
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------

    initial
    begin
        held_cnt[SIDE_A] = 0;
        held_cnt[SIDE_B] = 0;
        items_sent       = 0;
        words_checked    = 0;
        mismatches       = 0;
        dup_drops        = 0;
        full_drops       = 0;
        longest_reply    = 0;
        quiet_cycles     = 0;
        ops_seen         = '{0, 0, 0, 0};
        // single reset at the start, released on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_full_capacity();
        test_no_idle_stretch();
        test_random_sessions();
        finish_run();
    end

endmodule
